// ===== src/wlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wlc_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int ADDR_W    = 48;
  localparam int STAMP_W   = 64;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(ENTRIES);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPLY,
    S_SCAN,
    S_EVICT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic apply;
    logic scan_init;
    logic scan_step;
    logic evict;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/wlc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wlc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_free,
  input  wire wlc_pkg::dp_status_t status,
  output wlc_pkg::ctrl_cmd_t      cmd
);

  wlc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wlc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wlc_pkg::S_IDLE: begin
        if (in_valid) state_next = wlc_pkg::S_EXEC;
      end
      wlc_pkg::S_EXEC: begin
        state_next = wlc_pkg::S_APPLY;
      end
      wlc_pkg::S_APPLY: begin
        if (status.need_scan) begin
          state_next = wlc_pkg::S_SCAN;
        end else if (out_free) begin
          state_next = wlc_pkg::S_IDLE;
        end
      end
      wlc_pkg::S_SCAN: begin
        if (status.scan_done) state_next = wlc_pkg::S_EVICT;
      end
      wlc_pkg::S_EVICT: begin
        if (out_free) state_next = wlc_pkg::S_IDLE;
      end
      default: state_next = wlc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      wlc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      wlc_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      wlc_pkg::S_APPLY: begin
        if (status.need_scan) begin
          cmd.scan_init = 1'b1;
        end else if (out_free) begin
          cmd.apply    = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      wlc_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      wlc_pkg::S_EVICT: begin
        if (out_free) begin
          cmd.evict    = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/wlc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wlc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wlc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wlc_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic [wlc_pkg::ADDR_W-1:0]      in_address,
  input  wire wlc_pkg::ctrl_cmd_t              cmd,
  output wlc_pkg::dp_status_t                  status,
  output logic                                 res_hit,
  output logic [wlc_pkg::CNT_W-1:0]            res_count
);

  logic [wlc_pkg::ADDR_W-1:0]  win_low;
  logic [wlc_pkg::ADDR_W-1:0]  win_high;
  logic [wlc_pkg::CNT_W-1:0]   capacity;

  logic [1:0]                  op;
  logic [wlc_pkg::ADDR_W-1:0]  addr;

  logic [wlc_pkg::ENTRIES-1:0] valid;
  logic [wlc_pkg::ADDR_W-1:0]  tags [wlc_pkg::ENTRIES];
  logic [wlc_pkg::STAMP_W-1:0] stamp_mem [wlc_pkg::ENTRIES];
  logic [wlc_pkg::STAMP_W-1:0] time_now;
  logic [wlc_pkg::CNT_W-1:0]   count;

  logic                        hit;
  logic [wlc_pkg::IDX_W-1:0]   hit_idx;
  logic [wlc_pkg::IDX_W-1:0]   free_idx;
  logic                        refresh;
  logic                        fill;
  logic                        need_scan;

  logic [wlc_pkg::IDX_W:0]     scan_addr;
  logic                        rd_vld;
  logic [wlc_pkg::IDX_W-1:0]   rd_idx;
  logic [wlc_pkg::STAMP_W-1:0] rd_data;
  logic                        best_any;
  logic [wlc_pkg::IDX_W-1:0]   best_idx;
  logic [wlc_pkg::STAMP_W-1:0] best_stamp;

  logic                        hit_c;
  logic [wlc_pkg::IDX_W-1:0]   hit_idx_c;
  logic [wlc_pkg::IDX_W-1:0]   free_idx_c;
  logic [wlc_pkg::CNT_W-1:0]   cap_eff;
  logic                        win_ok;
  logic                        below_cap;
  logic                        is_lookup;
  logic                        is_insert;
  logic                        take_best;
  logic                        mem_we;
  logic [wlc_pkg::IDX_W-1:0]   mem_wa;

  // The address compare runs against every tag at once. Tags of valid
  // entries are unique, so the match index is an OR of the matching slots.
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
      if (valid[i] && (tags[i] == addr)) begin
        hit_c     = 1'b1;
        hit_idx_c = hit_idx_c | wlc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_idx_c = '0;
    for (int i = wlc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx_c = wlc_pkg::IDX_W'(i);
    end
  end

  assign cap_eff   = (capacity > wlc_pkg::CAP_MAX) ? wlc_pkg::CAP_MAX : capacity;
  assign win_ok    = (addr >= win_low) && (addr <= win_high) && (cap_eff != '0);
  assign below_cap = count < cap_eff;
  assign is_lookup = op == wlc_pkg::CMD_LOOKUP;
  assign is_insert = op == wlc_pkg::CMD_INSERT;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low  <= '0;
      win_high <= '1;
      capacity <= wlc_pkg::CAP_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wlc_pkg::REG_WINDOW_LOW:  win_low  <= cfg_data;
        wlc_pkg::REG_WINDOW_HIGH: win_high <= cfg_data;
        wlc_pkg::REG_CAPACITY:    capacity <= cfg_data[wlc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= in_cmd;
      addr <= in_address;
    end
    if (cmd.exec) begin
      hit       <= hit_c;
      hit_idx   <= hit_idx_c;
      free_idx  <= free_idx_c;
      refresh   <= hit_c && (is_lookup || (is_insert && win_ok));
      fill      <= is_insert && win_ok && !hit_c && below_cap;
      need_scan <= is_insert && win_ok && !hit_c && !below_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      time_now <= '0;
    end else if (cmd.apply) begin
      if (op == wlc_pkg::CMD_TICK) time_now <= time_now + 1'b1;
      if (fill) begin
        valid[free_idx] <= 1'b1;
        count           <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && fill) begin
      tags[free_idx] <= addr;
    end else if (cmd.evict) begin
      tags[best_idx] <= addr;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = hit_idx;
    if (cmd.apply && refresh) begin
      mem_we = 1'b1;
    end else if (cmd.apply && fill) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
    end else if (cmd.evict) begin
      mem_we = 1'b1;
      mem_wa = best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stamp_mem[mem_wa] <= time_now;
    rd_data <= stamp_mem[scan_addr[wlc_pkg::IDX_W-1:0]];
  end

  // The oldest search walks the stamp memory one slot a cycle. Strict less
  // than keeps the lowest slot on a tie.
  assign take_best = rd_vld && valid[rd_idx] && (!best_any || (rd_data < best_stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      best_any  <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      best_any  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (take_best) best_any <= 1'b1;
      if (scan_addr != (wlc_pkg::IDX_W + 1)'(wlc_pkg::ENTRIES)) begin
        rd_vld    <= 1'b1;
        scan_addr <= scan_addr + 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_idx <= scan_addr[wlc_pkg::IDX_W-1:0];
      if (take_best) begin
        best_idx   <= rd_idx;
        best_stamp <= rd_data;
      end
    end
  end

  assign status.need_scan = need_scan;
  assign status.scan_done = (scan_addr == (wlc_pkg::IDX_W + 1)'(wlc_pkg::ENTRIES)) && !rd_vld;

  assign res_hit   = hit && is_lookup;
  assign res_count = count + wlc_pkg::CNT_W'(fill);

endmodule

`default_nettype wire

// ===== src/windowed_lru_line_cache_top.sv =====
// Windowed LRU line cache: a fully associative store of line addresses with
// least-recently-used replacement.
// Input items arrive on the s_ channel: s_tuser carries the command (tick,
// lookup, insert) and s_tdata the line address. Every item gives exactly one
// result item on the m_ channel: the hit flag and the number of valid entries.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: index 0 is the low window bound, 1 the high window bound and
// 2 the capacity.
// An item goes through three steps from acceptance to a loaded result: it is
// taken, the tags are compared in parallel, and the store is updated. An insert
// that misses with the store at capacity also walks the stamp memory one slot
// a cycle through its single read port before the eviction.
// Items are worked on one at a time; a new item is accepted once the previous
// result sits in the output register. When the receiver stalls, the result
// holds there and the next item stops before its update until the register
// frees. Reset clears all valid bits, the entry count and the time counter and
// restores the configuration defaults; the stamp memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module windowed_lru_line_cache_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [wlc_pkg::ADDR_W-1:0]    s_tdata,   // address
  input  wire logic [1:0]                    s_tuser,   // cmd
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,   // hit, entries_used
  input  wire logic                          cfg_we,
  input  wire logic [wlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wlc_pkg::CFG_W-1:0]     cfg_data
);

  wlc_pkg::ctrl_cmd_t        cmd;
  wlc_pkg::dp_status_t       status;
  logic                      out_free;
  logic                      res_hit;
  logic [wlc_pkg::CNT_W-1:0] res_count;

  assign out_free = !m_tvalid || m_tready;

  wlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  wlc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (s_tuser),
    .in_address (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .res_hit    (res_hit),
    .res_count  (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) m_tdata <= {res_count, res_hit};
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register loaded while a result is still waiting");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again before the previous item finished");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] <= wlc_pkg::CAP_MAX))
    else $error("entry count above the store size");

  a_evict_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> status.scan_done)
    else $error("eviction without a finished oldest search");

endmodule

`default_nettype wire

// ===== sim/windowed_lru_line_cache_checker.sv =====
`timescale 1ns / 1ps

module windowed_lru_line_cache_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [wlc_pkg::ADDR_W-1:0]    s_tdata,   // address
  input  logic [1:0]                    s_tuser,   // cmd
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,   // hit, entries_used
  input  logic                          cfg_we,
  input  logic [wlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlc_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic                      hit;
    logic [wlc_pkg::CNT_W-1:0] used;
  } line_status_t;

  logic [wlc_pkg::ADDR_W-1:0]  line_addr  [wlc_pkg::ENTRIES];
  logic                        line_held  [wlc_pkg::ENTRIES];
  logic [wlc_pkg::STAMP_W-1:0] line_age   [wlc_pkg::ENTRIES];
  logic [wlc_pkg::STAMP_W-1:0] clock_now;
  logic [wlc_pkg::CFG_W-1:0]   win_low;
  logic [wlc_pkg::CFG_W-1:0]   win_high;
  logic [wlc_pkg::CNT_W-1:0]   cap_setting;

  line_status_t expected_status[$];
  int           fail_count = 0;

  function automatic int find_line(input logic [wlc_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
      if (line_held[i] && line_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic int lines_held();
    int n;
    n = 0;
    for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
      if (line_held[i]) n++;
    end
    return n;
  endfunction

  task automatic place_line(input logic [wlc_pkg::ADDR_W-1:0] addr);
    int cap_eff;
    int slot;
    cap_eff = (cap_setting > wlc_pkg::ENTRIES) ? wlc_pkg::ENTRIES : int'(cap_setting);
    if (addr < win_low || addr > win_high || cap_eff == 0) return;
    slot = find_line(addr);
    if (slot >= 0) begin
      line_age[slot] = clock_now;
      return;
    end
    if (lines_held() < cap_eff) begin
      for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
        if (!line_held[i]) begin
          slot = i;
          break;
        end
      end
    end else begin
      for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
        if (line_held[i] && (slot < 0 || line_age[i] < line_age[slot])) slot = i;
      end
    end
    if (slot < 0) return;
    line_addr[slot] = addr;
    line_age[slot]  = clock_now;
    line_held[slot] = 1'b1;
  endtask

  task automatic apply_command(input logic [1:0] cmd,
                               input logic [wlc_pkg::ADDR_W-1:0] addr,
                               output line_status_t status);
    int slot;
    status.hit = 1'b0;
    case (cmd)
      wlc_pkg::CMD_TICK: begin
        clock_now = clock_now + 1'b1;
      end
      wlc_pkg::CMD_LOOKUP: begin
        slot = find_line(addr);
        if (slot >= 0) begin
          line_age[slot] = clock_now;
          status.hit = 1'b1;
        end
      end
      wlc_pkg::CMD_INSERT: begin
        place_line(addr);
      end
      default: begin
      end
    endcase
    status.used = wlc_pkg::CNT_W'(lines_held());
  endtask

  always @(posedge clk) begin
    line_status_t got;
    line_status_t want;
    line_status_t next_status;
    if (rst) begin
      for (int i = 0; i < wlc_pkg::ENTRIES; i++) begin
        line_held[i] = 1'b0;
        line_addr[i] = '0;
        line_age[i]  = '0;
      end
      clock_now   = '0;
      win_low     = '0;
      win_high    = '1;
      cap_setting = wlc_pkg::CAP_MAX;
      expected_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wlc_pkg::REG_WINDOW_LOW:  win_low     = cfg_data;
          wlc_pkg::REG_WINDOW_HIGH: win_high    = cfg_data;
          wlc_pkg::REG_CAPACITY:    cap_setting = cfg_data[wlc_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.hit  = m_tdata[0];
        got.used = m_tdata[7:1];
        if (expected_status.size() == 0) begin
          $display("%0t: result with no item waiting, got hit %0d entries_used %0d",
                   $time, got.hit, got.used);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
            fail_count++;
          end
          if (got.used !== want.used) begin
            $display("%0t: entries_used expected %0d got %0d", $time, want.used, got.used);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_command(s_tuser, s_tdata, next_status);
        expected_status = {expected_status, next_status};
      end
    end
    pending <= expected_status.size();
    errors  <= fail_count;
  end

endmodule

// ===== sim/tb_windowed_lru_line_cache_top.sv =====
`timescale 1ns / 1ps

module tb_windowed_lru_line_cache_top;
  import wlc_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int POOL_SIZE = 96;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ADDR_W-1:0]    s_tdata = '0;   // address
  logic [1:0]           s_tuser = '0;   // cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // hit, entries_used
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;

  bit                   idle_on = 1'b1;
  bit                   long_hold = 1'b0;
  logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];

  windowed_lru_line_cache_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  windowed_lru_line_cache_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_window_cap(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                                input logic [CNT_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_WINDOW_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_CAPACITY;
    cfg_data  <= CFG_W'(cap);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random(input int count, input int span);
    int r;
    logic [1:0] cmd;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) cmd = CMD_TICK;
      else if (r < 55) cmd = CMD_LOOKUP;
      else if (r < 95) cmd = CMD_INSERT;
      else cmd = CMD_SPARE;
      if ($urandom_range(0, 99) < 85) addr = addr_pool[$urandom_range(0, span - 1)];
      else addr = rand_addr();
      send_item(cmd, addr);
    end
  endtask

  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] pb;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_MAX;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_LOOKUP, '0);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, ADDR_MAX);
    send_item(CMD_LOOKUP, ADDR_MAX);
    send_item(CMD_LOOKUP, ADDR_W'(1));
    send_item(CMD_SPARE, 48'h5A5A_A5A5_5A5A);
    send_item(CMD_TICK, 48'hA5A5_5A5A_A5A5);
    send_item(CMD_INSERT, '0);
    send_item(CMD_LOOKUP, '0);
    drain();
    set_window_cap('0, ADDR_MAX, CNT_W'(1));
    send_item(CMD_INSERT, ADDR_W'(123));
    send_item(CMD_LOOKUP, ADDR_MAX);
    drain();
    set_window_cap('0, ADDR_MAX, '0);
    send_item(CMD_INSERT, ADDR_W'(456));
    drain();
    set_window_cap('0, '0, '1);
    send_item(CMD_INSERT, ADDR_W'(789));
    send_item(CMD_INSERT, '0);
    drain();
    set_window_cap(ADDR_MAX, ADDR_MAX, '1);
    send_item(CMD_INSERT, ADDR_MAX);
    send_item(CMD_INSERT, '0);
    drain();
    set_window_cap(ADDR_W'(100), ADDR_W'(50), CAP_MAX);
    send_item(CMD_INSERT, ADDR_W'(75));
    send_item(CMD_TICK, '0);
    send_item(CMD_LOOKUP, ADDR_W'(123));
    drain();

    for (int p = 0; p < 8; p++) begin
      pa = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      pb = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      case (p)
        0: begin
          set_window_cap('0, ADDR_MAX, CAP_MAX);
          send_random(140, POOL_SIZE);
        end
        1: begin
          set_window_cap('0, ADDR_MAX, CNT_W'(8));
          long_hold = 1'b1;
          send_random(130, 14);
        end
        2: begin
          idle_on = 1'b0;
          set_window_cap((pa < pb) ? pa : pb, (pa < pb) ? pb : pa, '1);
          send_random(130, POOL_SIZE);
          idle_on = 1'b1;
        end
        3: begin
          set_window_cap('0, ADDR_MAX, CNT_W'(1));
          send_random(100, 4);
        end
        4: begin
          set_window_cap('0, ADDR_MAX, '0);
          send_random(40, 16);
        end
        5: begin
          set_window_cap(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, CAP_MAX);
          send_random(40, 16);
        end
        6: begin
          set_window_cap((pa < pb) ? pa : pb, (pa < pb) ? pb : pa,
                         CNT_W'($urandom_range(2, 70)));
          send_random(200, 40);
        end
        default: begin
          idle_on = 1'b0;
          set_window_cap('0, ADDR_MAX, CAP_MAX);
          send_random(270, 80);
        end
      endcase
      drain();
    end

    repeat (ENTRIES + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
